FILE: src/bls_pkg.sv
// shared constants, codes and controller/datapath interface types for the lifo stack
package bls_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_PEEK    = 2'd2;
  localparam logic [1:0] ACT_DISPLAY = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       we;
    logic       inc;
    logic       dec;
    logic       rd_idx;
    logic       idx_load;
    logic       idx_dec;
    logic       res_load;
    logic       word_rdata;
    logic [1:0] status;
    logic       last;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_zero;
  } dp_status_t;

endpackage

FILE: src/bounded_lifo_stack.sv
// top level of the bounded lifo stack of signed words
//
// An item is taken at a rising edge with start high and busy low. action_i selects
// push, pop, peek or display; push_value_i is used by push only.
// Each result sits on the result ports for one cycle with result_valid_o high;
// the receiver cannot stall, so every result must be taken as it appears.
// Push and every empty or overflow status: result in the next cycle, busy stays low,
// so such items can follow every cycle.
// Pop and peek: busy in state S_READ while the entry ram read completes; the word
// passes the ram read register and then the result registers, and busy holds off new items.
// Display of n elements: busy while they are read, one element per cycle from top to
// bottom, set by the single read port of the entry ram; last_of_run_o marks the last.
// The capacity register is written through cfg_valid_i/cfg_ready_o while idle;
// ready is low while busy. A value above the built depth acts as the depth.
// Reset empties the stack and sets the capacity to sixteen; the ram needs no clearing
// since only entries below the fill count are ever read.
module bounded_lifo_stack #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action_i,
  input  logic signed [bls_pkg::WORD_W-1:0] push_value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bls_pkg::CAP_W-1:0]         cfg_data_i,
  output logic                              result_valid_o,
  output logic signed [bls_pkg::WORD_W-1:0] word_out_o,
  output logic [1:0]                        status_o,
  output logic                              last_of_run_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);
  import bls_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;
  logic       busy_int;

  bls_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_int)
  );

  bls_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .push_value_i   (push_value_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .word_out_o     (word_out_o),
    .res_status_o   (status_o),
    .last_of_run_o  (last_of_run_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int;

endmodule

FILE: src/bls_ram.sv
// generic single-write, single-read ram with registered read data
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bls_ctrl.sv
// controller state machine sequencing push, pop, peek and display
module bls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         action_i,
  input  bls_pkg::dp_status_t status_i,
  output bls_pkg::ctrl_cmd_t  cmd_o,
  output logic               busy_o
);
  import bls_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DISP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    cmd_o.last   = 1'b1;
    cmd_o.status = ST_OK;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (action_i)
            ACT_PUSH: begin
              cmd_o.res_load = 1'b1;
              if (status_i.full) begin
                cmd_o.status = ST_OVERFLOW;
              end else begin
                cmd_o.we  = 1'b1;
                cmd_o.inc = 1'b1;
              end
            end
            ACT_POP: begin
              if (status_i.empty) begin
                cmd_o.res_load = 1'b1;
                cmd_o.status   = ST_EMPTY;
              end else begin
                // read top now, count drops at this edge
                cmd_o.dec = 1'b1;
                state_d   = S_READ;
              end
            end
            ACT_PEEK: begin
              if (status_i.empty) begin
                cmd_o.res_load = 1'b1;
                cmd_o.status   = ST_EMPTY;
              end else begin
                state_d = S_READ;
              end
            end
            ACT_DISPLAY: begin
              if (status_i.empty) begin
                cmd_o.res_load = 1'b1;
                cmd_o.status   = ST_EMPTY;
              end else begin
                cmd_o.idx_load = 1'b1;
                state_d        = S_DISP;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.word_rdata = 1'b1;
        state_d          = S_IDLE;
      end
      S_DISP: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.word_rdata = 1'b1;
        cmd_o.last       = status_i.idx_zero;
        if (status_i.idx_zero) begin
          state_d = S_IDLE;
        end else begin
          // fetch the next element down while this one goes out
          cmd_o.rd_idx  = 1'b1;
          cmd_o.idx_dec = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: src/bls_dpath.sv
// datapath: fill count, capacity register, display index, entry ram and result registers
module bls_dpath #(
  parameter int unsigned DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bls_pkg::ctrl_cmd_t                cmd_i,
  output bls_pkg::dp_status_t               status_o,
  input  logic signed [bls_pkg::WORD_W-1:0] push_value_i,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CAP_W-1:0]         cfg_data_i,
  output logic                              result_valid_o,
  output logic signed [bls_pkg::WORD_W-1:0] word_out_o,
  output logic [1:0]                        res_status_o,
  output logic                              last_of_run_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);
  import bls_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]    count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    raddr;
  logic [WORD_W-1:0] rdata;

  logic              valid_q;
  logic [WORD_W-1:0] word_q;
  logic [1:0]        stat_q;
  logic              last_q, empty_q, full_q;

  // full once the count reaches the smaller of capacity and depth
  function automatic logic full_f(input logic [CW-1:0] c, input logic [CAP_W-1:0] cap);
    return (CMPW'(c) >= CMPW'(cap)) || (c == CW'(DEPTH));
  endfunction

  always_comb begin
    count_d = count_q;
    if (cmd_i.inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_load) begin
      idx_d = AW'(count_q - CW'(1));
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - AW'(1);
    end
  end

  assign raddr = cmd_i.rd_idx ? (idx_q - AW'(1)) : AW'(count_q - CW'(1));

  bls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (AW'(count_q)),
    .wdata_i (push_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      valid_q <= cmd_i.res_load;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      word_q  <= cmd_i.word_rdata ? rdata : '0;
      stat_q  <= cmd_i.status;
      last_q  <= cmd_i.last;
      empty_q <= (count_d == '0);
      full_q  <= full_f(count_d, cap_q);
    end
  end

  assign status_o.empty    = (count_q == '0);
  assign status_o.full     = full_f(count_q, cap_q);
  assign status_o.idx_zero = (idx_q == '0);

  assign result_valid_o = valid_q;
  assign word_out_o     = word_q;
  assign res_status_o   = stat_q;
  assign last_of_run_o  = last_q;
  assign is_empty_o     = empty_q;
  assign is_full_o      = full_q;

endmodule
